@@ hdl/mlfq_pkg.sv @@
// Package for the multilevel feedback queue scheduler: sizes, codes, task word,
// and the command/status structs between controller and datapath.
// No dependencies; every other file but mlfq_ram imports it.
package mlfq_pkg;

  localparam int LEVELS = 3;
  localparam int TASKS  = 64;

  localparam int LV_W     = $clog2(LEVELS);
  localparam int TIDX_W   = $clog2(TASKS);
  localparam int QLEN_W   = TIDX_W + 1;
  localparam int QDEPTH   = LEVELS * TASKS;
  localparam int OP_W     = 3;
  localparam int REQ_W    = 6;
  localparam int BUD_W    = 16;
  localparam int OUT_LV_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [LV_W-1:0] LV_TOP    = LV_W'(LEVELS - 1);
  localparam logic [LV_W-1:0] LV_TOP_M1 = LV_W'(LEVELS - 2);

  localparam logic [BUD_W-1:0] TIME_BUDGET_RST = 16'd100;
  localparam logic [BUD_W-1:0] BOOST_RST       = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST       = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT    = 3'd0,
    OP_WAKE     = 3'd1,
    OP_BLOCK    = 3'd2,
    OP_EXIT     = 3'd3,
    OP_DISPATCH = 3'd4,
    OP_RUNDONE  = 3'd5,
    OP_TICK     = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_BLOCK = 2'd2,
    ST_EXIT  = 2'd3
  } st_e;

  typedef enum logic [1:0] {
    SW_DROP,
    SW_FIND,
    SW_DISP,
    SW_PURGE
  } sweep_e;

  typedef enum logic [1:0] {
    RD_REQ,
    RD_QDATA,
    RD_SCAN
  } rdsel_e;

  typedef enum logic [1:0] {
    TW_ADMIT,
    TW_STAT,
    TW_RUND,
    TW_PROMO
  } tw_e;

  typedef enum logic [2:0] {
    LV_HOLD,
    LV_TASK,
    LV_TOP_SEL,
    LV_DEC,
    LV_INC,
    LV_ZERO,
    LV_TGT,
    LV_PROMO
  } lvld_e;

  typedef enum logic [1:0] {
    TG_HOLD,
    TG_TOP,
    TG_TASK,
    TG_RUND
  } tgt_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_SWI,
    S_SWQ,
    S_SWT,
    S_SWE,
    S_SWEND,
    S_APP,
    S_BRD,
    S_BEV,
    S_BAPP,
    S_FIN,
    S_FIN2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [LV_W-1:0]  lvl;
    logic [BUD_W-1:0] bud;
    st_e              st;
  } tword_t;

  typedef struct packed {
    logic   in_load;
    logic   task_rd;
    rdsel_e rd_sel;
    logic   task_wr;
    tw_e    tw_kind;
    st_e    new_st;
    logic   q_rd;
    logic   ent_ld;
    logic   sw_start;
    logic   sw_step;
    sweep_e sw_mode;
    logic   sw_end;
    logic   append;
    logic   app_scan;
    lvld_e  lv_ld;
    tgt_e   tgt_ld;
    logic   scan_clr;
    logic   scan_inc;
    logic   cnt_dec;
    logic   cnt_load;
    logic   err_set;
    logic   res_cap;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            req_ok;
    st_e             st;
    logic            cnt_le1;
    logic            len_zero;
    logic            sw_last;
    logic            hit;
    logic            found;
    logic            lv_zero;
    logic            lv_top_m1;
    logic            scan_last;
    logic            promo_ok;
    logic            out_busy;
  } dp_sts_t;

endpackage

@@ hdl/mlfq_if.sv @@
// Handshake channels of the scheduler: event input, result output, config write.
// Depends on mlfq_pkg for field widths.
interface mlfq_evt_if import mlfq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [REQ_W-1:0] task_req;
  logic [BUD_W-1:0] ticks_used;
  modport source (output valid, op, task_req, ticks_used, input ready);
  modport sink (input valid, op, task_req, ticks_used, output ready);
endinterface

interface mlfq_res_if import mlfq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    chosen_task;
  logic [OUT_LV_W-1:0] chosen_level;
  logic                found;
  logic                error;
  modport source (output valid, chosen_task, chosen_level, found, error, input ready);
  modport sink (input valid, chosen_task, chosen_level, found, error, output ready);
endinterface

interface mlfq_cfg_if import mlfq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BUD_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/mlfq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mlfq_dp.sv @@
// Scheduler datapath: task table RAM, queue RAM, queue lengths, config and
// boost counter, sweep registers and result register. Uses mlfq_pkg, mlfq_ram.
module mlfq_dp import mlfq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [OP_W-1:0]      op_i,
  input  logic [REQ_W-1:0]     task_req_i,
  input  logic [BUD_W-1:0]     ticks_used_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BUD_W-1:0]     cfg_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [REQ_W-1:0]     chosen_task_o,
  output logic [OUT_LV_W-1:0]  chosen_level_o,
  output logic                 found_o,
  output logic                 error_o
);

  logic [OP_W-1:0]   op_q;
  logic [REQ_W-1:0]  req_q;
  logic [BUD_W-1:0]  used_q;
  logic [BUD_W-1:0]  tb_q, bi_q, cnt_q;
  logic [QLEN_W-1:0] qlen_q [LEVELS];
  logic [TASKS-1:0]  tvalid_q;
  logic              rv_q;
  logic [LV_W-1:0]   lv_q, tgt_q;
  logic [TIDX_W-1:0] rk_q, ent_q, scan_q;
  logic [QLEN_W-1:0] wk_q;
  logic              hit_q, found_q, err_q;
  logic [REQ_W-1:0]  res_task_q;
  logic [LV_W-1:0]   res_lvl_q;
  logic              out_valid_q;
  logic [REQ_W-1:0]  out_task_q;
  logic [LV_W-1:0]   out_lvl_q;
  logic              out_found_q, out_err_q;

  logic [TIDX_W-1:0] req_idx;
  logic              req_ok;
  tword_t            t_rdata, t_wdata, word;
  logic [TIDX_W-1:0] t_raddr, t_waddr;
  logic [TIDX_W-1:0] q_rdata, q_wdata;
  logic [$clog2(QDEPTH)-1:0] q_raddr, q_waddr;
  logic              q_we;
  logic [QLEN_W-1:0] qlen_cur;
  logic              q_room;
  logic              keep, take, ent_match;
  logic [LV_W-1:0]   rund_lv;
  logic [BUD_W-1:0]  rund_bud;

  assign req_idx  = TIDX_W'(req_q);
  assign req_ok   = ({3'b000, req_q} < 9'(TASKS));
  assign word     = rv_q ? t_rdata : tword_t'('0);
  assign qlen_cur = qlen_q[lv_q];
  assign q_room   = qlen_cur < QLEN_W'(TASKS);

  // run done: charge ticks, demote when the budget is spent, zero it at level 0
  always_comb begin
    rund_lv  = word.lvl;
    rund_bud = word.bud - used_q;
    if (used_q >= word.bud) begin
      if (word.lvl != '0) begin
        rund_lv  = word.lvl - 1'b1;
        rund_bud = tb_q;
      end else begin
        rund_bud = '0;
      end
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_QDATA: t_raddr = q_rdata;
      RD_SCAN:  t_raddr = scan_q;
      default:  t_raddr = req_idx;
    endcase
  end

  assign t_waddr = (cmd_i.tw_kind == TW_PROMO) ? scan_q : req_idx;

  always_comb begin
    unique case (cmd_i.tw_kind)
      TW_ADMIT: t_wdata = '{lvl: LV_TOP, bud: tb_q, st: ST_RUN};
      TW_STAT:  t_wdata = '{lvl: word.lvl, bud: word.bud, st: cmd_i.new_st};
      TW_RUND:  t_wdata = '{lvl: rund_lv, bud: rund_bud, st: word.st};
      TW_PROMO: t_wdata = '{lvl: word.lvl + 1'b1, bud: tb_q, st: word.st};
    endcase
  end

  mlfq_ram #(.WIDTH($bits(tword_t)), .DEPTH(TASKS)) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.task_wr),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (cmd_i.task_rd),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  // sweep decision for the entry held in ent_q
  assign ent_match = (ent_q == req_idx);
  always_comb begin
    unique case (cmd_i.sw_mode)
      SW_DROP:  keep = !ent_match;
      SW_FIND:  keep = 1'b1;
      SW_DISP:  keep = !(!found_q && word.st == ST_RUN);
      SW_PURGE: keep = (word.st == ST_EXIT);
    endcase
    take = (cmd_i.sw_mode == SW_DISP) && !keep;
  end

  assign q_raddr = {lv_q, rk_q};
  always_comb begin
    if (cmd_i.append) begin
      q_we    = q_room;
      q_waddr = {lv_q, qlen_cur[TIDX_W-1:0]};
      q_wdata = cmd_i.app_scan ? scan_q : req_idx;
    end else begin
      q_we    = cmd_i.sw_step && keep && (wk_q != {1'b0, rk_q});
      q_waddr = {lv_q, wk_q[TIDX_W-1:0]};
      q_wdata = ent_q;
    end
  end

  mlfq_ram #(.WIDTH(TIDX_W), .DEPTH(QDEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (cmd_i.q_rd),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q        <= TIME_BUDGET_RST;
      bi_q        <= BOOST_RST;
      cnt_q       <= BOOST_RST;
      qlen_q      <= '{default: '0};
      tvalid_q    <= '0;
      rv_q        <= 1'b0;
      lv_q        <= '0;
      tgt_q       <= '0;
      rk_q        <= '0;
      wk_q        <= '0;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TIME_BUDGET) begin
          tb_q <= cfg_data_i;
        end else begin
          bi_q <= cfg_data_i;
        end
      end
      if (cmd_i.cnt_load) begin
        cnt_q <= bi_q;
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.task_wr) begin
        tvalid_q[t_waddr] <= 1'b1;
      end
      if (cmd_i.task_rd) begin
        rv_q <= tvalid_q[t_raddr];
      end
      if (cmd_i.sw_end) begin
        qlen_q[lv_q] <= wk_q;
      end else if (cmd_i.append && q_room) begin
        qlen_q[lv_q] <= qlen_cur + 1'b1;
      end
      unique case (cmd_i.lv_ld)
        LV_HOLD:    lv_q <= lv_q;
        LV_TASK:    lv_q <= word.lvl;
        LV_TOP_SEL: lv_q <= LV_TOP;
        LV_DEC:     lv_q <= lv_q - 1'b1;
        LV_INC:     lv_q <= lv_q + 1'b1;
        LV_ZERO:    lv_q <= '0;
        LV_TGT:     lv_q <= tgt_q;
        LV_PROMO:   lv_q <= word.lvl + 1'b1;
      endcase
      unique case (cmd_i.tgt_ld)
        TG_HOLD: tgt_q <= tgt_q;
        TG_TOP:  tgt_q <= LV_TOP;
        TG_TASK: tgt_q <= word.lvl;
        TG_RUND: tgt_q <= rund_lv;
      endcase
      if (cmd_i.sw_start) begin
        rk_q  <= '0;
        wk_q  <= '0;
        hit_q <= 1'b0;
      end else if (cmd_i.sw_step) begin
        rk_q <= rk_q + 1'b1;
        if (keep) begin
          wk_q <= wk_q + 1'b1;
        end
        if (cmd_i.sw_mode == SW_FIND && ent_match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.in_load) begin
        found_q <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        if (cmd_i.sw_step && take) begin
          found_q <= 1'b1;
        end
        if (cmd_i.err_set) begin
          err_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q   <= op_i;
      req_q  <= task_req_i;
      used_q <= ticks_used_i;
    end
    if (cmd_i.ent_ld) begin
      ent_q <= q_rdata;
    end
    if (cmd_i.sw_step && take) begin
      res_task_q <= REQ_W'(ent_q);
      res_lvl_q  <= lv_q;
    end else if (cmd_i.res_cap) begin
      res_task_q <= req_q;
      res_lvl_q  <= req_ok ? word.lvl : '0;
    end
    if (cmd_i.out_load) begin
      out_task_q  <= res_task_q;
      out_lvl_q   <= res_lvl_q;
      out_found_q <= found_q;
      out_err_q   <= err_q;
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.req_ok    = req_ok;
    sts_o.st        = word.st;
    sts_o.cnt_le1   = (cnt_q <= BUD_W'(1));
    sts_o.len_zero  = (qlen_cur == '0);
    sts_o.sw_last   = (({1'b0, rk_q} + 1'b1) == qlen_cur);
    sts_o.hit       = hit_q;
    sts_o.found     = found_q;
    sts_o.lv_zero   = (lv_q == '0);
    sts_o.lv_top_m1 = (lv_q == LV_TOP_M1);
    sts_o.scan_last = (scan_q == TIDX_W'(TASKS - 1));
    sts_o.promo_ok  = (word.st == ST_RUN || word.st == ST_BLOCK) && (word.lvl != LV_TOP);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_task_o  = out_task_q;
  assign chosen_level_o = OUT_LV_W'(out_lvl_q);
  assign found_o        = out_found_q;
  assign error_o        = out_err_q;

endmodule

@@ hdl/mlfq_ctrl.sv @@
// Scheduler controller: sequences one event through task lookup, queue sweeps,
// appends and the boost scan. Uses mlfq_pkg; drives mlfq_dp by command struct.
module mlfq_ctrl import mlfq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  sweep_e mode;

  always_comb begin
    case (sts_i.op)
      OP_WAKE:     mode = SW_FIND;
      OP_DISPATCH: mode = SW_DISP;
      OP_TICK:     mode = SW_PURGE;
      default:     mode = SW_DROP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.sw_mode  = mode;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_RD;
        end
      end
      S_RD: begin
        cmd_o.task_rd = 1'b1;
        cmd_o.rd_sel  = RD_REQ;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_FIN;
        if (!sts_i.req_ok && (sts_i.op <= OP_EXIT || sts_i.op == OP_RUNDONE)) begin
          cmd_o.err_set = 1'b1;
        end else begin
          case (sts_i.op)
            OP_ADMIT: begin
              if (sts_i.st == ST_FREE || sts_i.st == ST_EXIT) begin
                cmd_o.task_wr = 1'b1;
                cmd_o.tw_kind = TW_ADMIT;
                cmd_o.lv_ld   = LV_TASK;
                cmd_o.tgt_ld  = TG_TOP;
                state_d       = S_SWI;
              end else begin
                cmd_o.err_set = 1'b1;
              end
            end
            OP_WAKE: begin
              if (sts_i.st == ST_BLOCK) begin
                cmd_o.task_wr = 1'b1;
                cmd_o.tw_kind = TW_STAT;
                cmd_o.new_st  = ST_RUN;
                cmd_o.lv_ld   = LV_TASK;
                cmd_o.tgt_ld  = TG_TASK;
                state_d       = S_SWI;
              end else if (sts_i.st != ST_RUN) begin
                cmd_o.err_set = 1'b1;
              end
            end
            OP_BLOCK: begin
              if (sts_i.st == ST_RUN) begin
                cmd_o.task_wr = 1'b1;
                cmd_o.tw_kind = TW_STAT;
                cmd_o.new_st  = ST_BLOCK;
              end else if (sts_i.st != ST_BLOCK) begin
                cmd_o.err_set = 1'b1;
              end
            end
            OP_EXIT: begin
              if (sts_i.st == ST_RUN || sts_i.st == ST_BLOCK) begin
                cmd_o.task_wr = 1'b1;
                cmd_o.tw_kind = TW_STAT;
                cmd_o.new_st  = ST_EXIT;
              end else if (sts_i.st == ST_FREE) begin
                cmd_o.err_set = 1'b1;
              end
            end
            OP_DISPATCH: begin
              cmd_o.lv_ld = LV_TOP_SEL;
              state_d     = S_SWI;
            end
            OP_RUNDONE: begin
              if (sts_i.st == ST_FREE) begin
                cmd_o.err_set = 1'b1;
              end else begin
                cmd_o.task_wr = 1'b1;
                cmd_o.tw_kind = TW_RUND;
                cmd_o.lv_ld   = LV_TASK;
                cmd_o.tgt_ld  = TG_RUND;
                state_d       = S_SWI;
              end
            end
            OP_TICK: begin
              if (sts_i.cnt_le1) begin
                cmd_o.cnt_load = 1'b1;
                cmd_o.lv_ld    = LV_ZERO;
                state_d        = S_SWI;
              end else begin
                cmd_o.cnt_dec = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SWI: begin
        cmd_o.sw_start = 1'b1;
        state_d        = sts_i.len_zero ? S_SWEND : S_SWQ;
      end
      S_SWQ: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_SWT;
      end
      S_SWT: begin
        // queue word is out; fetch that task's status
        cmd_o.ent_ld  = 1'b1;
        cmd_o.task_rd = 1'b1;
        cmd_o.rd_sel  = RD_QDATA;
        state_d       = S_SWE;
      end
      S_SWE: begin
        cmd_o.sw_step = 1'b1;
        state_d       = sts_i.sw_last ? S_SWEND : S_SWQ;
      end
      S_SWEND: begin
        cmd_o.sw_end = 1'b1;
        state_d      = S_FIN;
        case (sts_i.op)
          OP_ADMIT, OP_RUNDONE: begin
            cmd_o.lv_ld = LV_TGT;
            state_d     = S_APP;
          end
          OP_WAKE: begin
            if (!sts_i.hit) begin
              cmd_o.lv_ld = LV_TGT;
              state_d     = S_APP;
            end
          end
          OP_DISPATCH: begin
            if (sts_i.found) begin
              state_d = S_DONE;
            end else if (!sts_i.lv_zero) begin
              cmd_o.lv_ld = LV_DEC;
              state_d     = S_SWI;
            end
          end
          OP_TICK: begin
            if (sts_i.lv_top_m1) begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_BRD;
            end else begin
              cmd_o.lv_ld = LV_INC;
              state_d     = S_SWI;
            end
          end
          default: ;
        endcase
      end
      S_APP: begin
        cmd_o.append = 1'b1;
        state_d      = S_FIN;
      end
      S_BRD: begin
        cmd_o.task_rd = 1'b1;
        cmd_o.rd_sel  = RD_SCAN;
        state_d       = S_BEV;
      end
      S_BEV: begin
        if (sts_i.promo_ok) begin
          cmd_o.task_wr = 1'b1;
          cmd_o.tw_kind = TW_PROMO;
          cmd_o.lv_ld   = LV_PROMO;
          state_d       = S_BAPP;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = sts_i.scan_last ? S_FIN : S_BRD;
        end
      end
      S_BAPP: begin
        cmd_o.append   = 1'b1;
        cmd_o.app_scan = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d        = sts_i.scan_last ? S_FIN : S_BRD;
      end
      S_FIN: begin
        cmd_o.task_rd = 1'b1;
        cmd_o.rd_sel  = RD_REQ;
        state_d       = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.res_cap = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

endmodule

@@ hdl/multilevel_feedback_queue_scheduler.sv @@
// Multilevel feedback queue scheduler, top level.
// Channels: evt_i takes one event transaction (op, task_req, ticks_used);
// res_o returns exactly one result transaction per event (chosen_task,
// chosen_level, found, error); cfg_i writes time_budget (index 0) or
// boost_interval (index 1) and is always ready; write it only while idle.
// One event is worked at a time. Block, exit, wake of a running task and an
// ordinary tick pass from acceptance through task read, evaluate and two
// finish states to the result state, then return to idle; admit, run done and
// wake of a blocked task add a sweep of the task's queue and an append (wake
// only if the task was not in it), dispatch sweeps levels from the top until
// one yields a runnable task or level 0 is swept. A sweep has a start and an
// end step and takes each queued entry through queue RAM read, task table read
// and compact, as both RAMs have a single read port. A boost tick sweeps every
// level below the top, then reads each task and appends those it promotes.
// The result sits in an output register; a stalled receiver only holds the
// next event in its final state, and a new event is accepted while a result
// waits. Reset empties all queues, frees all tasks (per-task valid bits, no
// clearing pass) and reloads both registers and the boost countdown.
// Uses mlfq_pkg, mlfq_if, mlfq_ctrl, mlfq_dp.
module multilevel_feedback_queue_scheduler import mlfq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  mlfq_evt_if.sink   evt_i,
  mlfq_res_if.source res_o,
  mlfq_cfg_if.sink   cfg_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  mlfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (evt_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlfq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (evt_i.op),
    .task_req_i     (evt_i.task_req),
    .ticks_used_i   (evt_i.ticks_used),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .chosen_task_o  (res_o.chosen_task),
    .chosen_level_o (res_o.chosen_level),
    .found_o        (res_o.found),
    .error_o        (res_o.error)
  );

endmodule

@@ bench/multilevel_feedback_queue_scheduler_tb.sv @@
// Testbench for the multilevel feedback queue scheduler: directed and random
// event streams checked against a behavioral scheduler model kept in the bench.
// Depends on mlfq_pkg, mlfq_if and the scheduler RTL.
`timescale 1ns / 100ps

module multilevel_feedback_queue_scheduler_tb;
  import mlfq_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 5_000_000;

  typedef struct packed {
    logic [REQ_W-1:0]    tsk;
    logic [OUT_LV_W-1:0] lvl;
    logic                found;
    logic                err;
  } sched_res_t;

  logic clk_i;
  logic rst_ni;

  mlfq_evt_if evt ();
  mlfq_res_if res ();
  mlfq_cfg_if cfg ();

  multilevel_feedback_queue_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt.sink),
    .res_o  (res.source),
    .cfg_i  (cfg.sink)
  );

  // scheduler model state
  logic [BUD_W-1:0]  mdl_budget_cfg;
  logic [BUD_W-1:0]  mdl_boost_cfg;
  logic [BUD_W-1:0]  mdl_countdown;
  logic [TIDX_W-1:0] run_q [LEVELS][$];
  int                mdl_level [TASKS];
  logic [BUD_W-1:0]  mdl_budget [TASKS];
  st_e               mdl_status [TASKS];

  sched_res_t pending_res [$];
  int  mismatches;
  int  sent_cnt, checked_cnt, boost_cnt, found_cnt;
  int  cycle_cnt;
  int  stall_hold;
  bit  sink_steady, src_steady;
  int  last_dispatched;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("multilevel_feedback_queue_scheduler_tb: errors");
      $finish;
    end
  end

  // receiver: random back-pressure, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      res.ready  <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else if (sink_steady) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(99) >= 15);
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch #%0d at result %0d: %s got %0d want %0d",
             mismatches, checked_cnt, what, got, want);
  endtask

  always @(posedge clk_i) begin
    sched_res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_res.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        want = pending_res.pop_front();
        if (res.chosen_task !== want.tsk) report("chosen_task", res.chosen_task, want.tsk);
        if (res.chosen_level !== want.lvl) report("chosen_level", res.chosen_level, want.lvl);
        if (res.found !== want.found) report("found", res.found, want.found);
        if (res.error !== want.err) report("error", res.error, want.err);
      end
      checked_cnt++;
    end
  end

  function automatic void mdl_reset();
    mdl_budget_cfg = TIME_BUDGET_RST;
    mdl_boost_cfg  = BOOST_RST;
    mdl_countdown  = BOOST_RST;
    for (int l = 0; l < LEVELS; l++) run_q[l].delete();
    for (int t = 0; t < TASKS; t++) begin
      mdl_level[t]  = 0;
      mdl_budget[t] = '0;
      mdl_status[t] = ST_FREE;
    end
  endfunction

  function automatic void requeue_tail(int t, int lv);
    for (int l = 0; l < LEVELS; l++)
      for (int k = run_q[l].size() - 1; k >= 0; k--)
        if (run_q[l][k] == t) run_q[l].delete(k);
    mdl_level[t] = lv;
    run_q[lv].push_back(TIDX_W'(t));
  endfunction

  function automatic sched_res_t schedule_event(logic [OP_W-1:0] op, int req,
                                                logic [BUD_W-1:0] used);
    sched_res_t r;
    st_e st;
    bit hit;
    int lv;
    st = mdl_status[req];
    r.found = 1'b0;
    r.err   = 1'b0;
    r.tsk   = REQ_W'(req);
    case (op)
      OP_ADMIT: begin
        if (st == ST_FREE || st == ST_EXIT) begin
          mdl_budget[req] = mdl_budget_cfg;
          mdl_status[req] = ST_RUN;
          requeue_tail(req, LEVELS - 1);
        end else r.err = 1'b1;
      end
      OP_WAKE: begin
        if (st == ST_BLOCK) begin
          mdl_status[req] = ST_RUN;
          hit = 0;
          foreach (run_q[mdl_level[req]][k])
            if (run_q[mdl_level[req]][k] == req) hit = 1;
          if (!hit) run_q[mdl_level[req]].push_back(TIDX_W'(req));
        end else if (st != ST_RUN) r.err = 1'b1;
      end
      OP_BLOCK: begin
        if (st == ST_RUN) mdl_status[req] = ST_BLOCK;
        else if (st != ST_BLOCK) r.err = 1'b1;
      end
      OP_EXIT: begin
        if (st == ST_RUN || st == ST_BLOCK) mdl_status[req] = ST_EXIT;
        else if (st != ST_EXIT) r.err = 1'b1;
      end
      OP_DISPATCH: begin
        // highest level first; skipped entries stay in place
        for (int l = LEVELS - 1; l >= 0 && !r.found; l--)
          for (int k = 0; k < run_q[l].size(); k++)
            if (mdl_status[run_q[l][k]] == ST_RUN) begin
              r.tsk   = run_q[l][k];
              r.lvl   = OUT_LV_W'(l);
              r.found = 1'b1;
              run_q[l].delete(k);
              break;
            end
      end
      OP_RUNDONE: begin
        if (st == ST_FREE) r.err = 1'b1;
        else begin
          lv = mdl_level[req];
          if (used >= mdl_budget[req]) begin
            if (lv > 0) begin
              lv--;
              mdl_budget[req] = mdl_budget_cfg;
            end else mdl_budget[req] = '0;
          end else mdl_budget[req] = mdl_budget[req] - used;
          requeue_tail(req, lv);
        end
      end
      OP_TICK: begin
        if (mdl_countdown <= 1) begin
          boost_cnt++;
          for (int t = 0; t < TASKS; t++)
            if ((mdl_status[t] == ST_RUN || mdl_status[t] == ST_BLOCK) &&
                mdl_level[t] < LEVELS - 1) begin
              mdl_budget[t] = mdl_budget_cfg;
              requeue_tail(t, mdl_level[t] + 1);
            end
          mdl_countdown = mdl_boost_cfg;
        end else mdl_countdown--;
      end
      default: ;
    endcase
    if (!r.found) r.lvl = OUT_LV_W'(mdl_level[req]);
    return r;
  endfunction

  task automatic send_event(input logic [OP_W-1:0] op, input int req,
                            input logic [BUD_W-1:0] used);
    sched_res_t r;
    @(negedge clk_i);
    if (!src_steady && $urandom_range(99) < 15) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    evt.valid      <= 1'b1;
    evt.op         <= op;
    evt.task_req   <= REQ_W'(req);
    evt.ticks_used <= used;
    do @(posedge clk_i); while (!evt.ready);
    r = schedule_event(op, req, used);
    if (op == OP_DISPATCH && r.found) last_dispatched = r.tsk;
    if (r.found) found_cnt++;
    pending_res.push_back(r);
    sent_cnt++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    evt.valid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BUD_W-1:0] val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    if (idx == CFG_TIME_BUDGET) mdl_budget_cfg = val;
    else mdl_boost_cfg = val;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic test_lifecycle();
    send_event(OP_WAKE, 5, 16'd0);      // wake of a free task
    send_event(OP_BLOCK, 5, 16'd0);
    send_event(OP_EXIT, 5, 16'd0);
    send_event(OP_RUNDONE, 5, 16'd0);
    send_event(OP_DISPATCH, 9, 16'd0);  // empty scheduler
    send_event(OP_ADMIT, 0, 16'd0);
    send_event(OP_ADMIT, 63, 16'd0);
    send_event(OP_ADMIT, 0, 16'd0);     // already live
    send_event(OP_BLOCK, 0, 16'd0);
    send_event(OP_BLOCK, 0, 16'd0);
    send_event(OP_DISPATCH, 0, 16'd0);  // skips blocked entry
    send_event(OP_WAKE, 0, 16'd0);
    send_event(OP_WAKE, 0, 16'd0);
    send_event(OP_RUNDONE, 63, 16'd0);
    send_event(OP_RUNDONE, 63, 16'hFFFF);
    send_event(OP_RUNDONE, 63, 16'hFFFF);
    send_event(OP_RUNDONE, 63, 16'hFFFF); // bottom level, budget clamps
    send_event(OP_EXIT, 0, 16'd0);
    send_event(OP_EXIT, 0, 16'd0);
    send_event(OP_WAKE, 0, 16'd0);
    send_event(OP_ADMIT, 0, 16'd0);     // re-admit after exit
    send_event(OP_SPARE, 42, 16'h5A5A);
    send_event(OP_DISPATCH, 0, 16'd0);
    drain();
  endtask

  task automatic test_boost();
    write_reg(CFG_BOOST, 16'd1);
    write_reg(CFG_TIME_BUDGET, 16'd1);
    send_event(OP_ADMIT, 10, 16'd0);
    send_event(OP_RUNDONE, 10, 16'd1);
    send_event(OP_RUNDONE, 10, 16'd1);
    send_event(OP_BLOCK, 10, 16'd0);
    send_event(OP_TICK, 0, 16'd0);
    send_event(OP_TICK, 0, 16'd0);
    send_event(OP_WAKE, 10, 16'd0);
    send_event(OP_DISPATCH, 0, 16'd0);
    drain();
  endtask

  task automatic random_events(input int n, input int pool);
    int sel, req;
    logic [OP_W-1:0] op;
    logic [BUD_W-1:0] used;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 14) op = OP_ADMIT;
      else if (sel < 26) op = OP_WAKE;
      else if (sel < 36) op = OP_BLOCK;
      else if (sel < 41) op = OP_EXIT;
      else if (sel < 66) op = OP_DISPATCH;
      else if (sel < 86) op = OP_RUNDONE;
      else if (sel < 98) op = OP_TICK;
      else op = OP_SPARE;
      req = ($urandom_range(99) < 85) ? $urandom_range(pool - 1) : $urandom_range(TASKS - 1);
      if (op == OP_RUNDONE && $urandom_range(1)) req = last_dispatched;
      case ($urandom_range(3))
        0: used = BUD_W'($urandom_range(3));
        1: used = BUD_W'($urandom_range(mdl_budget_cfg));
        default: used = BUD_W'($urandom);
      endcase
      send_event(op, req, used);
    end
  endtask

  task automatic test_random_phases();
    write_reg(CFG_TIME_BUDGET, 16'd100);
    write_reg(CFG_BOOST, 16'd1000);
    random_events(180, 16);
    drain();
    write_reg(CFG_TIME_BUDGET, 16'd1);
    write_reg(CFG_BOOST, 16'd2);
    random_events(180, 12);
    drain();
    write_reg(CFG_TIME_BUDGET, 16'hFFFF);
    write_reg(CFG_BOOST, 16'hFFFF);
    random_events(120, 64);
    drain();
    write_reg(CFG_TIME_BUDGET, 16'd7);
    write_reg(CFG_BOOST, 16'd5);
    sink_steady = 1;
    src_steady  = 1;
    random_events(100, 8);
    sink_steady = 0;
    src_steady  = 0;
    random_events(100, 24);
    drain();
  endtask

  task automatic test_backpressure();
    // receiver holds off while events keep coming, then sender waits it out
    stall_hold = 400;
    random_events(40, 10);
    drain();
    random_events(40, 10);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    evt.valid = 1'b0;
    evt.op = '0;
    evt.task_req = '0;
    evt.ticks_used = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    mismatches = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    boost_cnt = 0;
    found_cnt = 0;
    cycle_cnt = 0;
    stall_hold = 0;
    sink_steady = 0;
    src_steady = 0;
    last_dispatched = 0;
    mdl_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_lifecycle();
    test_boost();
    test_random_phases();
    test_backpressure();

    if (pending_res.size() != 0) report("results left over", pending_res.size(), 0);
    $display("ran %0d events, %0d results checked, %0d dispatches found a task,",
             sent_cnt, checked_cnt, found_cnt);
    $display("%0d boosts across five budget/interval settings", boost_cnt);
    if (mismatches == 0) begin
      $display("multilevel_feedback_queue_scheduler_tb: clean");
    end else begin
      $display("multilevel_feedback_queue_scheduler_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mlfq_pkg.sv
hdl/mlfq_if.sv
hdl/mlfq_ram.sv
hdl/mlfq_dp.sv
hdl/mlfq_ctrl.sv
hdl/multilevel_feedback_queue_scheduler.sv
bench/multilevel_feedback_queue_scheduler_tb.sv
